@@ hdl/first_fit_page_allocator_macros.svh @@
// ----------------------------------------------------------------------------
// First-fit page allocator assertion macros
// Shared property shorthands for the allocator's RTL checks.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_PAGE_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_PAGE_ALLOCATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FFPA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FFPA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/ffpa_pkg.sv @@
// ----------------------------------------------------------------------------
// First-fit page allocator package
// Sizes, status and opcode codes, microcode encoding and the control store.
// ----------------------------------------------------------------------------
`default_nettype none

package ffpa_pkg;

   // Map geometry.
   localparam int FRAME_COUNT = 1024;
   localparam int SLOT_COUNT  = 1024;
   localparam int PAGE_SHIFT  = 22;

   localparam int WORD_W      = 32;
   localparam int BIT_W       = $clog2(WORD_W);
   localparam int FRAME_WORDS = (FRAME_COUNT + WORD_W - 1) / WORD_W;
   localparam int SLOT_WORDS  = (SLOT_COUNT + WORD_W - 1) / WORD_W;
   localparam int FRAME_ROW_W = (FRAME_WORDS > 1) ? $clog2(FRAME_WORDS) : 1;
   localparam int SLOT_ROW_W  = (SLOT_WORDS > 1) ? $clog2(SLOT_WORDS) : 1;
   localparam int ROW_W       = (FRAME_ROW_W > SLOT_ROW_W) ? FRAME_ROW_W : SLOT_ROW_W;
   localparam int FRAME_NUM_W = FRAME_ROW_W + BIT_W;
   localparam int SLOT_NUM_W  = SLOT_ROW_W + BIT_W;

   localparam logic [ROW_W-1:0] FRAME_LAST = ROW_W'(FRAME_WORDS - 1);
   localparam logic [ROW_W-1:0] SLOT_LAST  = ROW_W'(SLOT_WORDS - 1);

   // Valid bits of the last row of each map.
   localparam logic [WORD_W-1:0] FRAME_TAIL_MASK = (FRAME_COUNT % WORD_W == 0) ?
      {WORD_W{1'b1}} : WORD_W'((64'd1 << (FRAME_COUNT % WORD_W)) - 64'd1);
   localparam logic [WORD_W-1:0] SLOT_TAIL_MASK = (SLOT_COUNT % WORD_W == 0) ?
      {WORD_W{1'b1}} : WORD_W'((64'd1 << (SLOT_COUNT % WORD_W)) - 64'd1);

   // Frames 0 and 1 are reserved out of reset.
   localparam logic [WORD_W-1:0] FRAME_ROW0_RESET = 32'h0000_0003;

   // Directory word flag bits.
   localparam logic [31:0] BIT_PRESENT  = 32'h1;
   localparam logic [31:0] BIT_WRITABLE = 32'h2;
   localparam logic [31:0] BIT_LARGE    = 32'h1 << 7;
   localparam logic [31:0] DIR_FLAGS    = BIT_LARGE | BIT_WRITABLE | BIT_PRESENT;

   // Interface field widths and codes.
   localparam int INDEX_W  = 10;
   localparam int STATUS_W = 2;
   localparam int FNUM_W   = 10;
   localparam int ADDR_W   = 32;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_FRAME = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NO_SLOT  = 2'd2;

   // Datapath actions.
   localparam int ACT_W = 4;
   localparam logic [ACT_W-1:0] ACT_NONE        = 4'd0;
   localparam logic [ACT_W-1:0] ACT_ACCEPT      = 4'd1;
   localparam logic [ACT_W-1:0] ACT_SLOT_START  = 4'd2;
   localparam logic [ACT_W-1:0] ACT_SLOT_SCAN   = 4'd3;
   localparam logic [ACT_W-1:0] ACT_NO_SLOT     = 4'd4;
   localparam logic [ACT_W-1:0] ACT_FRAME_START = 4'd5;
   localparam logic [ACT_W-1:0] ACT_FRAME_SCAN  = 4'd6;
   localparam logic [ACT_W-1:0] ACT_NO_FRAME    = 4'd7;
   localparam logic [ACT_W-1:0] ACT_COMMIT      = 4'd8;
   localparam logic [ACT_W-1:0] ACT_RESULT      = 4'd9;
   localparam logic [ACT_W-1:0] ACT_WR_READ     = 4'd10;
   localparam logic [ACT_W-1:0] ACT_WR_WRITE    = 4'd11;

   // Jump conditions.
   localparam int JC_W = 3;
   localparam logic [JC_W-1:0] JC_NEVER     = 3'd0;
   localparam logic [JC_W-1:0] JC_ALWAYS    = 3'd1;
   localparam logic [JC_W-1:0] JC_REQ_WRITE = 3'd2;
   localparam logic [JC_W-1:0] JC_HIT       = 3'd3;
   localparam logic [JC_W-1:0] JC_RSP_TAKEN = 3'd4;

   // Hold conditions: the step repeats while the condition is true.
   localparam int HC_W = 2;
   localparam logic [HC_W-1:0] HC_NONE     = 2'd0;
   localparam logic [HC_W-1:0] HC_NO_REQ   = 2'd1;
   localparam logic [HC_W-1:0] HC_SCANNING = 2'd2;
   localparam logic [HC_W-1:0] HC_ALWAYS   = 2'd3;

   // Program addresses.
   localparam int PC_W = 4;
   localparam logic [PC_W-1:0] PC_IDLE        = 4'd0;
   localparam logic [PC_W-1:0] PC_SLOT_START  = 4'd1;
   localparam logic [PC_W-1:0] PC_SLOT_SCAN   = 4'd2;
   localparam logic [PC_W-1:0] PC_NO_SLOT     = 4'd3;
   localparam logic [PC_W-1:0] PC_FRAME_START = 4'd4;
   localparam logic [PC_W-1:0] PC_FRAME_SCAN  = 4'd5;
   localparam logic [PC_W-1:0] PC_NO_FRAME    = 4'd6;
   localparam logic [PC_W-1:0] PC_COMMIT      = 4'd7;
   localparam logic [PC_W-1:0] PC_RESULT      = 4'd8;
   localparam logic [PC_W-1:0] PC_WR_READ     = 4'd9;
   localparam logic [PC_W-1:0] PC_WR_WRITE    = 4'd10;
   localparam logic [PC_W-1:0] PC_LAST        = PC_WR_WRITE;

   typedef struct packed {
      logic [ACT_W-1:0] act;
      logic [JC_W-1:0]  jump_cond;
      logic [PC_W-1:0]  jump_pc;
      logic [HC_W-1:0]  hold_cond;
   } ucode_type;

   // Control from the sequencer to the datapath.
   typedef struct packed {
      logic [ACT_W-1:0] act;
      logic             req_fire;
   } ctl_type;

   // Status from the datapath to the sequencer.
   typedef struct packed {
      logic hit;
      logic at_last;
   } stat_type;

   function automatic ucode_type uword(input logic [ACT_W-1:0] act,
                                       input logic [JC_W-1:0]  jc,
                                       input logic [PC_W-1:0]  jpc,
                                       input logic [HC_W-1:0]  hc);
      ucode_type w;
      w.act       = act;
      w.jump_cond = jc;
      w.jump_pc   = jpc;
      w.hold_cond = hc;
      return w;
   endfunction

   // Control store: one word per program step.
   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type w;
      case (pc)
         PC_IDLE:        w = uword(ACT_ACCEPT, JC_REQ_WRITE, PC_WR_READ, HC_NO_REQ);
         PC_SLOT_START:  w = uword(ACT_SLOT_START, JC_NEVER, PC_IDLE, HC_NONE);
         PC_SLOT_SCAN:   w = uword(ACT_SLOT_SCAN, JC_HIT, PC_FRAME_START, HC_SCANNING);
         PC_NO_SLOT:     w = uword(ACT_NO_SLOT, JC_ALWAYS, PC_RESULT, HC_NONE);
         PC_FRAME_START: w = uword(ACT_FRAME_START, JC_NEVER, PC_IDLE, HC_NONE);
         PC_FRAME_SCAN:  w = uword(ACT_FRAME_SCAN, JC_HIT, PC_COMMIT, HC_SCANNING);
         PC_NO_FRAME:    w = uword(ACT_NO_FRAME, JC_ALWAYS, PC_RESULT, HC_NONE);
         PC_COMMIT:      w = uword(ACT_COMMIT, JC_NEVER, PC_IDLE, HC_NONE);
         PC_RESULT:      w = uword(ACT_RESULT, JC_RSP_TAKEN, PC_IDLE, HC_ALWAYS);
         PC_WR_READ:     w = uword(ACT_WR_READ, JC_NEVER, PC_IDLE, HC_NONE);
         PC_WR_WRITE:    w = uword(ACT_WR_WRITE, JC_ALWAYS, PC_RESULT, HC_NONE);
         default:        w = uword(ACT_NONE, JC_ALWAYS, PC_IDLE, HC_NONE);
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

@@ hdl/ffpa_ram.sv @@
// ----------------------------------------------------------------------------
// Bitmap word RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ffpa_ram #(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic [ffpa_pkg::WORD_W-1:0] wr_data,
   input  logic [AW-1:0]              rd_addr,
   output logic [ffpa_pkg::WORD_W-1:0] rd_data
);
   import ffpa_pkg::*;

   logic [WORD_W-1:0] mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, with registered read data.
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

@@ hdl/ffpa_datapath.sv @@
// ----------------------------------------------------------------------------
// First-fit page allocator datapath
// Both bitmaps, the row scanner, the captured hits and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ffpa_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  ffpa_pkg::ctl_type              ctl,
   input  logic [ffpa_pkg::INDEX_W-1:0]   req_slot_index,
   input  logic                           req_slot_present,
   output ffpa_pkg::stat_type             stat,
   output logic [ffpa_pkg::STATUS_W-1:0]  rsp_status,
   output logic [ffpa_pkg::ADDR_W-1:0]    rsp_virt_addr,
   output logic [ffpa_pkg::FNUM_W-1:0]    rsp_frame_number,
   output logic [ffpa_pkg::ADDR_W-1:0]    rsp_dir_word
);
   import ffpa_pkg::*;

   // Captured request.
   logic [INDEX_W-1:0] idx_ff;
   logic               present_ff;

   // Scan pointers: ptr is the row being read, chk the row being examined.
   logic [ROW_W-1:0] ptr_ff, ptr_in;
   logic [ROW_W-1:0] chk_ff, chk_in;

   // Row valid flags; a row that is not valid reads as its reset value.
   logic slot_vld_ff  [SLOT_WORDS];
   logic frame_vld_ff [FRAME_WORDS];
   logic slot_rvld_ff, frame_rvld_ff, frame_rrow0_ff;

   // RAM ports.
   logic [SLOT_ROW_W-1:0]  slot_raddr, slot_waddr;
   logic [FRAME_ROW_W-1:0] frame_raddr;
   logic [WORD_W-1:0]      slot_rdata, frame_rdata, slot_wdata;
   logic                   slot_wen, frame_wen;

   // Captured hits.
   logic [SLOT_ROW_W-1:0]  slot_hit_row_ff;
   logic [BIT_W-1:0]       slot_hit_bit_ff;
   logic [WORD_W-1:0]      slot_hit_word_ff;
   logic [FRAME_ROW_W-1:0] frame_hit_row_ff;
   logic [BIT_W-1:0]       frame_hit_bit_ff;
   logic [WORD_W-1:0]      frame_hit_word_ff;

   // Scan logic.
   logic [WORD_W-1:0] slot_word, frame_word, scan_word, scan_mask, free_bits;
   logic [WORD_W-1:0] wr_bit, wr_word;
   logic [ROW_W-1:0]  scan_last;
   logic [BIT_W-1:0]  pos;
   logic              is_frame, wr_in_range;
   logic [SLOT_NUM_W-1:0]  slot_num;
   logic [FRAME_NUM_W-1:0] frame_num;

   // Result registers.
   logic [STATUS_W-1:0] status_ff;
   logic [ADDR_W-1:0]   virt_ff, dword_ff;
   logic [FNUM_W-1:0]   fnum_ff;

   // Request capture.
   always_ff @(posedge clock) begin
      if (ctl.req_fire) begin
         idx_ff     <= req_slot_index;
         present_ff <= req_slot_present;
      end
   end

   // Scan pointer update.
   always_comb begin
      ptr_in = ptr_ff;
      chk_in = chk_ff;
      case (ctl.act)
         ACT_SLOT_START, ACT_FRAME_START: begin
            ptr_in = ROW_W'(1);
            chk_in = '0;
         end
         ACT_SLOT_SCAN, ACT_FRAME_SCAN: begin
            ptr_in = ptr_ff + ROW_W'(1);
            chk_in = ptr_ff;
         end
         default: begin
            ptr_in = ptr_ff;
            chk_in = chk_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      chk_ff <= chk_in;
   end

   // Read addresses of the two maps.
   always_comb begin
      case (ctl.act)
         ACT_SLOT_START: slot_raddr = '0;
         ACT_WR_READ:    slot_raddr = SLOT_ROW_W'(idx_ff >> BIT_W);
         default:        slot_raddr = ptr_ff[SLOT_ROW_W-1:0];
      endcase
      case (ctl.act)
         ACT_FRAME_START: frame_raddr = '0;
         default:         frame_raddr = ptr_ff[FRAME_ROW_W-1:0];
      endcase
   end

   ffpa_ram #(.DEPTH(SLOT_WORDS), .AW(SLOT_ROW_W)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wen),
      .wr_addr (slot_waddr),
      .wr_data (slot_wdata),
      .rd_addr (slot_raddr),
      .rd_data (slot_rdata)
   );

   ffpa_ram #(.DEPTH(FRAME_WORDS), .AW(FRAME_ROW_W)) u_frame_ram (
      .clock   (clock),
      .wr_en   (frame_wen),
      .wr_addr (frame_hit_row_ff),
      .wr_data (frame_hit_word_ff),
      .rd_addr (frame_raddr),
      .rd_data (frame_rdata)
   );

   // Valid flag of the row being read travels with the read data.
   always_ff @(posedge clock) begin
      slot_rvld_ff   <= slot_vld_ff[slot_raddr];
      frame_rvld_ff  <= frame_vld_ff[frame_raddr];
      frame_rrow0_ff <= (frame_raddr == '0);
   end

   // Effective map words, with reset values for rows never written.
   always_comb begin
      slot_word = slot_rvld_ff ? slot_rdata : '0;
      if (frame_rvld_ff) begin
         frame_word = frame_rdata;
      end else begin
         frame_word = frame_rrow0_ff ? FRAME_ROW0_RESET : '0;
      end
   end

   // First-free search over the examined row.
   always_comb begin
      is_frame  = (ctl.act == ACT_FRAME_SCAN);
      scan_word = is_frame ? frame_word : slot_word;
      scan_last = is_frame ? FRAME_LAST : SLOT_LAST;
      scan_mask = '1;
      if (chk_ff == scan_last) begin
         scan_mask = is_frame ? FRAME_TAIL_MASK : SLOT_TAIL_MASK;
      end
      // Slot zero is never handed out.
      if (!is_frame && chk_ff == '0) begin
         scan_mask[0] = 1'b0;
      end
      free_bits = ~scan_word & scan_mask;
      pos = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (free_bits[i]) begin
            pos = BIT_W'(i);
         end
      end
      stat.hit     = |free_bits;
      stat.at_last = (chk_ff == scan_last);
   end

   // Hit capture: row, bit and the row with that bit already set.
   always_ff @(posedge clock) begin
      if (ctl.act == ACT_SLOT_SCAN && stat.hit) begin
         slot_hit_row_ff  <= chk_ff[SLOT_ROW_W-1:0];
         slot_hit_bit_ff  <= pos;
         slot_hit_word_ff <= slot_word | (WORD_W'(1) << pos);
      end
      if (ctl.act == ACT_FRAME_SCAN && stat.hit) begin
         frame_hit_row_ff  <= chk_ff[FRAME_ROW_W-1:0];
         frame_hit_bit_ff  <= pos;
         frame_hit_word_ff <= frame_word | (WORD_W'(1) << pos);
      end
   end

   // Slot map write: commit of an allocation or a present-mark update.
   always_comb begin
      wr_in_range = (32'(idx_ff) < 32'(SLOT_COUNT));
      wr_bit      = WORD_W'(1) << idx_ff[BIT_W-1:0];
      wr_word     = present_ff ? (slot_word | wr_bit) : (slot_word & ~wr_bit);
      slot_wen    = (ctl.act == ACT_COMMIT) || (ctl.act == ACT_WR_WRITE && wr_in_range);
      if (ctl.act == ACT_COMMIT) begin
         slot_waddr = slot_hit_row_ff;
         slot_wdata = slot_hit_word_ff;
      end else begin
         slot_waddr = SLOT_ROW_W'(idx_ff >> BIT_W);
         slot_wdata = wr_word;
      end
      frame_wen = (ctl.act == ACT_COMMIT);
   end

   // Row valid flags are set by the first write of a row.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_WORDS; i++) begin
            slot_vld_ff[i] <= 1'b0;
         end
         for (int i = 0; i < FRAME_WORDS; i++) begin
            frame_vld_ff[i] <= 1'b0;
         end
      end else begin
         if (slot_wen) begin
            slot_vld_ff[slot_waddr] <= 1'b1;
         end
         if (frame_wen) begin
            frame_vld_ff[frame_hit_row_ff] <= 1'b1;
         end
      end
   end

   // Result registers.
   assign slot_num  = {slot_hit_row_ff, slot_hit_bit_ff};
   assign frame_num = {frame_hit_row_ff, frame_hit_bit_ff};

   always_ff @(posedge clock) begin
      case (ctl.act)
         ACT_COMMIT: begin
            status_ff <= ST_OK;
            virt_ff   <= ADDR_W'(64'(slot_num) << PAGE_SHIFT);
            fnum_ff   <= FNUM_W'(frame_num);
            dword_ff  <= ADDR_W'(64'(frame_num) << PAGE_SHIFT) | DIR_FLAGS;
         end
         ACT_NO_SLOT, ACT_NO_FRAME, ACT_WR_WRITE: begin
            if (ctl.act == ACT_NO_SLOT) begin
               status_ff <= ST_NO_SLOT;
            end else if (ctl.act == ACT_NO_FRAME) begin
               status_ff <= ST_NO_FRAME;
            end else begin
               status_ff <= ST_OK;
            end
            virt_ff  <= '0;
            fnum_ff  <= '0;
            dword_ff <= '0;
         end
         default: begin
            status_ff <= status_ff;
         end
      endcase
   end

   assign rsp_status       = status_ff;
   assign rsp_virt_addr    = virt_ff;
   assign rsp_frame_number = fnum_ff;
   assign rsp_dir_word     = dword_ff;

endmodule

`default_nettype wire

@@ hdl/ffpa_seq.sv @@
// ----------------------------------------------------------------------------
// First-fit page allocator sequencer
// Step counter, control store fetch, jump and hold evaluation, handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

`include "first_fit_page_allocator_macros.svh"

module ffpa_seq (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_opcode,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  ffpa_pkg::stat_type stat,
   output ffpa_pkg::ctl_type  ctl
);
   import ffpa_pkg::*;

   logic [PC_W-1:0] pc_ff, pc_in;
   ucode_type       uc;
   logic            jump, hold;

   // Fetch the control word of the current step.
   assign uc = ucode_rom(pc_ff);

   // Jump and hold conditions.
   always_comb begin
      case (uc.jump_cond)
         JC_NEVER:     jump = 1'b0;
         JC_ALWAYS:    jump = 1'b1;
         JC_REQ_WRITE: jump = req_valid && (req_opcode == OP_WRITE);
         JC_HIT:       jump = stat.hit;
         JC_RSP_TAKEN: jump = rsp_ready;
         default:      jump = 1'b1;
      endcase
      case (uc.hold_cond)
         HC_NONE:     hold = 1'b0;
         HC_NO_REQ:   hold = !req_valid;
         HC_SCANNING: hold = !stat.at_last;
         HC_ALWAYS:   hold = 1'b1;
         default:     hold = 1'b0;
      endcase
   end

   // Next step: jump first, then hold, else fall through.
   always_comb begin
      if (jump) begin
         pc_in = uc.jump_pc;
      end else if (hold) begin
         pc_in = pc_ff;
      end else begin
         pc_in = pc_ff + PC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   // Handshakes and datapath control.
   assign req_ready    = (uc.act == ACT_ACCEPT);
   assign rsp_valid    = (uc.act == ACT_RESULT);
   assign ctl.act      = uc.act;
   assign ctl.req_fire = req_ready && req_valid;

   // Checks.
   `FFPA_ASSERT_NOW(a_pc_in_program, 1'b1, pc_ff <= PC_LAST, "step counter left the program")
   `FFPA_ASSERT_NOW(a_one_side_open, 1'b1, !(req_ready && rsp_valid),
                    "request and result offered together")
   `FFPA_ASSERT_NEXT(a_alloc_scans, req_valid && req_ready && (req_opcode == OP_ALLOC),
                     pc_ff == PC_SLOT_START, "allocation did not start the slot scan")

endmodule

`default_nettype wire

@@ hdl/first_fit_page_allocator.sv @@
// Steps: a write request reads and then writes its slot map row before its result;
// an allocate request scans k slot rows and then, if a slot is free, m frame rows,
// k and m being the rows scanned (at most 32 each, one bitmap RAM row per cycle).
// Throughput: one request at a time; the next is taken the cycle after the result.
// Reset: synchronous; row valid flags make both maps read as their reset
// contents at once, so no clearing pass runs after reset.
// ----------------------------------------------------------------------------
// First-fit page allocator
// Large-page allocator over a frame bitmap and a directory present map,
// controlled by a microcoded sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_page_allocator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_opcode,
   input  logic [ffpa_pkg::INDEX_W-1:0]  req_slot_index,
   input  logic                          req_slot_present,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ffpa_pkg::STATUS_W-1:0] rsp_status,
   output logic [ffpa_pkg::ADDR_W-1:0]   rsp_virt_addr,
   output logic [ffpa_pkg::FNUM_W-1:0]   rsp_frame_number,
   output logic [ffpa_pkg::ADDR_W-1:0]   rsp_dir_word
);
   import ffpa_pkg::*;

   ctl_type  ctl;
   stat_type stat;

   // Program sequencer.
   ffpa_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .stat       (stat),
      .ctl        (ctl)
   );

   // Bitmaps and result datapath.
   ffpa_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .req_slot_index   (req_slot_index),
      .req_slot_present (req_slot_present),
      .stat             (stat),
      .rsp_status       (rsp_status),
      .rsp_virt_addr    (rsp_virt_addr),
      .rsp_frame_number (rsp_frame_number),
      .rsp_dir_word     (rsp_dir_word)
   );

endmodule

`default_nettype wire

@@ tb/sv/first_fit_page_allocator_test.sv @@
// ----------------------------------------------------------------------------
// First-fit page allocator testbench
// Drives allocate and directory-write requests through the valid/ready
// request channel. Each response is checked field by field against a
// bit-accurate software copy of both maps. A directed list opens the run.
// Random request sequences follow, with stalls on both sides, one long
// response hold and one pause of the sender.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_page_allocator_test;

   timeunit 1ns;
   timeprecision 1ps;

   import ffpa_pkg::*;

   // One response of the block.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   virt_addr;
      logic [FNUM_W-1:0]   frame_number;
      logic [ADDR_W-1:0]   dir_word;
   } page_grant_type;

   // One directed request, with its response typed in when 'typed' is set.
   typedef struct packed {
      bit                 typed;
      logic               opcode;
      logic [INDEX_W-1:0] slot_index;
      logic               slot_present;
      page_grant_type     grant;
   } directed_row_type;

   localparam page_grant_type WRITE_DONE = '{ST_OK, 32'h0, 10'h0, 32'h0};
   localparam int LONG_HOLD      = 300;
   localparam int DRAIN_CYCLES   = 80;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DIRECTED_COUNT = 22;

   localparam directed_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{1'b1, OP_ALLOC, 10'd0,     1'b0, '{ST_OK, 32'h0040_0000, 10'd2, 32'h0080_0083}},
      '{1'b1, OP_WRITE, 10'd0,     1'b1, WRITE_DONE},
      '{1'b1, OP_ALLOC, 10'd1023,  1'b1, '{ST_OK, 32'h0080_0000, 10'd3, 32'h00C0_0083}},
      '{1'b1, OP_WRITE, 10'd1023,  1'b1, WRITE_DONE},
      '{1'b1, OP_WRITE, 10'd1,     1'b0, WRITE_DONE},
      '{1'b1, OP_ALLOC, 10'd0,     1'b0, '{ST_OK, 32'h0040_0000, 10'd4, 32'h0100_0083}},
      '{1'b1, OP_WRITE, 10'd3,     1'b1, WRITE_DONE},
      '{1'b1, OP_ALLOC, 10'h2AA,   1'b1, '{ST_OK, 32'h0100_0000, 10'd5, 32'h0140_0083}},
      '{1'b1, OP_WRITE, 10'h2AA,   1'b1, WRITE_DONE},
      '{1'b1, OP_WRITE, 10'h155,   1'b0, WRITE_DONE},
      '{1'b1, OP_WRITE, 10'h3FF,   1'b0, WRITE_DONE},
      '{1'b1, OP_WRITE, 10'd0,     1'b0, WRITE_DONE},
      '{1'b0, OP_WRITE, 10'd5,     1'b1, WRITE_DONE},
      '{1'b0, OP_WRITE, 10'd6,     1'b1, WRITE_DONE},
      '{1'b0, OP_WRITE, 10'd7,     1'b1, WRITE_DONE},
      '{1'b1, OP_ALLOC, 10'h155,   1'b0, '{ST_OK, 32'h0200_0000, 10'd6, 32'h0180_0083}},
      '{1'b0, OP_WRITE, 10'd2,     1'b0, WRITE_DONE},
      '{1'b0, OP_ALLOC, 10'd0,     1'b0, WRITE_DONE},
      '{1'b0, OP_WRITE, 10'h3FE,   1'b1, WRITE_DONE},
      '{1'b0, OP_ALLOC, 10'h3FF,   1'b1, WRITE_DONE},
      '{1'b0, OP_WRITE, 10'h200,   1'b1, WRITE_DONE},
      '{1'b0, OP_ALLOC, 10'h1FF,   1'b0, WRITE_DONE}
   };

   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                req_valid        = 1'b0;
   logic                req_ready;
   logic                req_opcode       = OP_ALLOC;
   logic [INDEX_W-1:0]  req_slot_index   = '0;
   logic                req_slot_present = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready        = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [ADDR_W-1:0]   rsp_virt_addr;
   logic [FNUM_W-1:0]   rsp_frame_number;
   logic [ADDR_W-1:0]   rsp_dir_word;

   // Software copy of the two maps.
   bit frame_taken [FRAME_COUNT];
   bit slot_taken  [SLOT_COUNT];

   page_grant_type expected_grants [$];
   int  mismatch_count = 0;
   int  quiet_cycles   = 0;
   bit  no_idle        = 1'b0;
   bit  hold_rsp       = 1'b0;

   first_fit_page_allocator dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_slot_index   (req_slot_index),
      .req_slot_present (req_slot_present),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_virt_addr    (rsp_virt_addr),
      .rsp_frame_number (rsp_frame_number),
      .rsp_dir_word     (rsp_dir_word)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Lowest slot from 1 upward that is not present; 0 when all are present.
   function automatic int first_free_slot();
      for (int s = 1; s < SLOT_COUNT; s++) begin
         if (!slot_taken[s]) return s;
      end
      return 0;
   endfunction

   // Lowest free frame; -1 when every frame is taken.
   function automatic int lowest_free_frame();
      for (int f = 0; f < FRAME_COUNT; f++) begin
         if (!frame_taken[f]) return f;
      end
      return -1;
   endfunction

   // Applies one request to the map copy and returns the response it causes.
   function automatic page_grant_type predict_grant(input logic op,
                                                    input logic [INDEX_W-1:0] idx,
                                                    input logic pres);
      page_grant_type g;
      int slot;
      int frame;
      g = WRITE_DONE;
      if (op == OP_WRITE) begin
         if (int'(idx) < SLOT_COUNT) slot_taken[idx] = pres;
         return g;
      end
      slot = first_free_slot();
      if (slot == 0) begin
         g.status = ST_NO_SLOT;
         return g;
      end
      frame = lowest_free_frame();
      if (frame < 0) begin
         g.status = ST_NO_FRAME;
         return g;
      end
      frame_taken[frame] = 1'b1;
      slot_taken[slot]   = 1'b1;
      g.virt_addr    = ADDR_W'(slot) << PAGE_SHIFT;
      g.frame_number = FNUM_W'(frame);
      g.dir_word     = (ADDR_W'(frame) << PAGE_SHIFT) | DIR_FLAGS;
      return g;
   endfunction

   // Offers one request, waits for it to be taken and records its response.
   task automatic send_req(input logic op, input logic [INDEX_W-1:0] idx,
                           input logic pres, input bit typed = 1'b0,
                           input page_grant_type typed_grant = WRITE_DONE);
      page_grant_type g;
      int gap;
      gap = 0;
      if (!no_idle && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 17);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_opcode       <= op;
      req_slot_index   <= idx;
      req_slot_present <= pres;
      do @(posedge clock); while (!req_ready);
      g = predict_grant(op, idx, pres);
      expected_grants.push_back(typed ? typed_grant : g);
   endtask

   // One random sequence: a lone allocation, a bootstrap run of present
   // marks followed by an allocation, a release and reuse, or pure noise.
   task automatic random_sequence(output int sent);
      int kind;
      int base;
      int len;
      int s;
      kind = $urandom_range(0, 99);
      sent = 0;
      if (kind < 45) begin
         send_req(OP_ALLOC, INDEX_W'($urandom), 1'($urandom));
         sent = 1;
      end else if (kind < 60) begin
         base = $urandom_range(1, SLOT_COUNT - 1);
         len  = $urandom_range(2, 6);
         for (int k = 0; k < len; k++) begin
            s = base + k;
            if (s >= SLOT_COUNT) s = s - SLOT_COUNT + 1;
            send_req(OP_WRITE, INDEX_W'(s), 1'b1);
         end
         send_req(OP_ALLOC, INDEX_W'($urandom), 1'($urandom));
         sent = len + 1;
      end else if (kind < 80) begin
         send_req(OP_WRITE, INDEX_W'($urandom_range(1, SLOT_COUNT - 1)), 1'b0);
         send_req(OP_ALLOC, INDEX_W'($urandom), 1'($urandom));
         sent = 2;
      end else begin
         send_req(1'($urandom), INDEX_W'($urandom), 1'($urandom));
         sent = 1;
      end
   endtask

   // Response side: random stall bursts, one long hold on request, and the
   // comparison of every accepted response with the oldest expectation.
   initial begin
      int stall_left;
      page_grant_type want;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            if (expected_grants.size() == 0) begin
               $error("response with no request outstanding: status %0d", rsp_status);
               mismatch_count++;
            end else begin
               want = expected_grants.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  mismatch_count++;
               end
               if (rsp_virt_addr !== want.virt_addr) begin
                  $error("virt_addr: expected %h, got %h", want.virt_addr, rsp_virt_addr);
                  mismatch_count++;
               end
               if (rsp_frame_number !== want.frame_number) begin
                  $error("frame_number: expected %0d, got %0d",
                         want.frame_number, rsp_frame_number);
                  mismatch_count++;
               end
               if (rsp_dir_word !== want.dir_word) begin
                  $error("dir_word: expected %h, got %h", want.dir_word, rsp_dir_word);
                  mismatch_count++;
               end
            end
         end
         if (hold_rsp) begin
            hold_rsp   = 1'b0;
            stall_left = LONG_HOLD;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!no_idle && $urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(1, 17) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: ends the run when nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("** first_fit_page_allocator: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Main sequence.
   initial begin
      int sent;
      int total;
      bit held;
      bit paused;

      for (int f = 0; f < FRAME_COUNT; f++) frame_taken[f] = (f < 2);
      for (int k = 0; k < SLOT_COUNT; k++) slot_taken[k] = 1'b0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed list: reset contents, extremes of the index, slot zero.
      foreach (DIRECTED_ROWS[i]) begin
         send_req(DIRECTED_ROWS[i].opcode, DIRECTED_ROWS[i].slot_index,
                  DIRECTED_ROWS[i].slot_present, DIRECTED_ROWS[i].typed,
                  DIRECTED_ROWS[i].grant);
      end

      // Random sequences, with quiet stretches, one long response hold and
      // one pause of the sender until every response is back.
      total  = 0;
      held   = 1'b0;
      paused = 1'b0;
      while (total < 720) begin
         no_idle = ((total / 150) % 3 == 1);
         if (!held && total >= 200) begin
            held     = 1'b1;
            hold_rsp = 1'b1;
         end
         if (!paused && total >= 450) begin
            paused = 1'b1;
            req_valid <= 1'b0;
            while (expected_grants.size() != 0) @(posedge clock);
         end
         random_sequence(sent);
         total += sent;
      end

      // Closing stretch with no idling on either side.
      no_idle = 1'b1;
      total = 0;
      while (total < 60) begin
         random_sequence(sent);
         total += sent;
      end
      req_valid <= 1'b0;

      while (expected_grants.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("** first_fit_page_allocator: PASSED **");
      end else begin
         $display("** first_fit_page_allocator: FAILED **");
      end
      $finish;
   end

endmodule

`default_nettype wire
